// File: rtl/jajm_pkg.sv
// Package for the joystick arm jog mapper: payload, configuration and control types,
// register indexes, reset values and fixed-point constants. No dependencies.
package jajm_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef struct packed {
      logic [63:0] axes_first;
      logic [63:0] axes_second;
      logic [15:0] button_bits;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] base_velocity;
      logic signed [15:0] shoulder_velocity;
      logic signed [15:0] upper_velocity;
      logic signed [15:0] elbow_velocity;
      logic signed [15:0] tilt_velocity;
      logic signed [15:0] roll_velocity;
      logic               claw_request;
      logic [7:0]         claw_port;
      logic [7:0]         claw_position;
   } rsp_payload_type;

   typedef struct packed {
      logic [23:0]        axis_select;
      logic [23:0]        button_select;
      logic signed [15:0] throttle_low;
      logic signed [15:0] throttle_high;
      logic [15:0]        throttle_gain;
      logic [7:0]         claw_low;
      logic [7:0]         claw_high;
      logic [7:0]         servo_channel;
   } cfg_type;

   typedef enum logic [2:0] {
      REG_AXIS_SELECT   = 3'd0,
      REG_BUTTON_SELECT = 3'd1,
      REG_THROTTLE_LOW  = 3'd2,
      REG_THROTTLE_HIGH = 3'd3,
      REG_THROTTLE_GAIN = 3'd4,
      REG_CLAW_LOW      = 3'd5,
      REG_CLAW_HIGH     = 3'd6,
      REG_SERVO_CHANNEL = 3'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      VEL_BASE     = 3'd0,
      VEL_SHOULDER = 3'd1,
      VEL_UPPER    = 3'd2,
      VEL_ELBOW    = 3'd3,
      VEL_TILT     = 3'd4,
      VEL_ROLL     = 3'd5
   } vel_index_type;

   localparam logic [2:0] VEL_COUNT = 3'd6;

   typedef struct packed {
      logic          capture;
      logic          thr_issue;
      logic          thr_finish;
      logic          vel_issue;
      vel_index_type issue_idx;
      logic          vel_finish;
      vel_index_type finish_idx;
      logic          out_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   localparam logic [23:0]        AXIS_SELECT_RESET   = 24'd7754768;
   localparam logic [23:0]        BUTTON_SELECT_RESET = 24'd12228658;
   localparam logic signed [15:0] THROTTLE_LOW_RESET  = -16'sd32767;
   localparam logic signed [15:0] THROTTLE_HIGH_RESET = 16'sd32767;
   localparam logic [15:0]        THROTTLE_GAIN_RESET = 16'd26214;
   localparam logic [7:0]         CLAW_LOW_RESET      = 8'd8;
   localparam logic [7:0]         CLAW_HIGH_RESET     = 8'd63;
   localparam logic [7:0]         SERVO_CHANNEL_RESET = 8'd12;
   localparam logic [7:0]         CLAW_POSITION_RESET = 8'd63;

   localparam logic [16:0] THR_FLOOR = 17'd13107;
   localparam logic [16:0] THR_ONE   = 17'd65536;

   localparam logic signed [17:0] COEF_SHOULDER_FWD = -18'sd25559;
   localparam logic signed [17:0] COEF_UPPER_FWD    = 18'sd30147;
   localparam logic signed [17:0] COEF_SHOULDER_BWD = 18'sd29491;
   localparam logic signed [17:0] COEF_UPPER_BWD    = -18'sd26214;
   localparam logic signed [17:0] COEF_ONE          = 18'sd32768;
   localparam logic signed [17:0] COEF_ONE_NEG      = -18'sd32768;

   localparam logic signed [15:0] DZ_ACT1     = 16'sd3276;
   localparam logic signed [15:0] DZ_ACT1_NEG = -16'sd3276;
   localparam logic signed [15:0] DZ_ELBOW     = 16'sd6553;
   localparam logic signed [15:0] DZ_ELBOW_NEG = -16'sd6553;

endpackage

// File: rtl/jajm_stream_if.sv
// Valid/ready channel interface carrying one payload per beat.
// The payload type is set at instantiation; no package dependency.
interface jajm_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/jajm_csr.sv
// APB-style configuration register file for the jog mapper.
// Depends on jajm_pkg for the register indexes, reset values and cfg_type.
module jajm_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [jajm_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [jajm_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [jajm_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output jajm_pkg::cfg_type                   cfg
);
   import jajm_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write_en;

   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            REG_AXIS_SELECT:   cfg_in.axis_select   = csr_pwdata[23:0];
            REG_BUTTON_SELECT: cfg_in.button_select = csr_pwdata[23:0];
            REG_THROTTLE_LOW:  cfg_in.throttle_low  = csr_pwdata[15:0];
            REG_THROTTLE_HIGH: cfg_in.throttle_high = csr_pwdata[15:0];
            REG_THROTTLE_GAIN: cfg_in.throttle_gain = csr_pwdata[15:0];
            REG_CLAW_LOW:      cfg_in.claw_low      = csr_pwdata[7:0];
            REG_CLAW_HIGH:     cfg_in.claw_high     = csr_pwdata[7:0];
            REG_SERVO_CHANNEL: cfg_in.servo_channel = csr_pwdata[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_AXIS_SELECT:   csr_prdata = {8'd0, cfg_ff.axis_select};
         REG_BUTTON_SELECT: csr_prdata = {8'd0, cfg_ff.button_select};
         REG_THROTTLE_LOW:  csr_prdata = {16'd0, cfg_ff.throttle_low};
         REG_THROTTLE_HIGH: csr_prdata = {16'd0, cfg_ff.throttle_high};
         REG_THROTTLE_GAIN: csr_prdata = {16'd0, cfg_ff.throttle_gain};
         REG_CLAW_LOW:      csr_prdata = {24'd0, cfg_ff.claw_low};
         REG_CLAW_HIGH:     csr_prdata = {24'd0, cfg_ff.claw_high};
         REG_SERVO_CHANNEL: csr_prdata = {24'd0, cfg_ff.servo_channel};
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.axis_select   <= AXIS_SELECT_RESET;
         cfg_ff.button_select <= BUTTON_SELECT_RESET;
         cfg_ff.throttle_low  <= THROTTLE_LOW_RESET;
         cfg_ff.throttle_high <= THROTTLE_HIGH_RESET;
         cfg_ff.throttle_gain <= THROTTLE_GAIN_RESET;
         cfg_ff.claw_low      <= CLAW_LOW_RESET;
         cfg_ff.claw_high     <= CLAW_HIGH_RESET;
         cfg_ff.servo_channel <= SERVO_CHANNEL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/jajm_ctrl.sv
// Sequencing state machine for the jog mapper: throttle, six velocity products, result load.
// Depends on jajm_pkg for cmd_type, status_type and the velocity indexes.
module jajm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  jajm_pkg::status_type status,
   output jajm_pkg::cmd_type    cmd
);
   import jajm_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_THR  = 5'b00010,
      ST_THRF = 5'b00100,
      ST_VEL  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type  state_ff;
   state_type  state_in;
   logic [2:0] cnt_ff;
   logic [2:0] cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_THR;
            end
         end
         ST_THR: begin
            cmd.thr_issue = 1'b1;
            state_in      = ST_THRF;
         end
         ST_THRF: begin
            cmd.thr_finish = 1'b1;
            cnt_in         = 3'd0;
            state_in       = ST_VEL;
         end
         ST_VEL: begin
            cmd.vel_issue  = (cnt_ff != VEL_COUNT);
            cmd.issue_idx  = vel_index_type'(cnt_ff);
            cmd.vel_finish = (cnt_ff != 3'd0);
            cmd.finish_idx = vel_index_type'(cnt_ff - 3'd1);
            if (cnt_ff == VEL_COUNT) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// File: rtl/jajm_dp.sv
// Datapath of the jog mapper: sample registers, operand selection, one shared multiplier,
// rounding and saturation, claw position state and the output register. Depends on jajm_pkg.
module jajm_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  jajm_pkg::cfg_type         cfg,
   input  jajm_pkg::cmd_type         cmd,
   output jajm_pkg::status_type      status,
   input  jajm_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output jajm_pkg::rsp_payload_type rsp_payload
);
   import jajm_pkg::*;

   function automatic logic signed [15:0] read_axis(input logic [3:0] idx,
                                                    input logic [63:0] lo4,
                                                    input logic [63:0] hi4);
      logic [63:0] word;
      word = idx[2] ? hi4 : lo4;
      if (idx[3]) begin
         return 16'sd0;
      end
      return word[idx[1:0]*16 +: 16];
   endfunction

   function automatic logic signed [17:0] ext18(input logic signed [15:0] v);
      return {{2{v[15]}}, v};
   endfunction

   logic [63:0]        a1_ff;
   logic [63:0]        a2_ff;
   logic [15:0]        bits_ff;
   logic [16:0]        thr_ff;
   logic [16:0]        thr_in;
   logic signed [35:0] prod_ff;
   logic signed [35:0] prod_in;
   logic signed [15:0] vel_ff [VEL_COUNT];
   logic signed [15:0] vel_res;
   logic [7:0]         claw_pos_ff;
   logic [7:0]         claw_pos_in;
   logic               latch_ff;
   logic               latch_in;
   logic               claw_req;
   logic               out_valid_ff;
   logic               out_valid_in;
   rsp_payload_type    out_pl_ff;

   logic signed [15:0] ax_base, ax_roll, ax_act1, ax_act2, ax_elbow, ax_thr;
   logic               b_wplus, b_wminus, b_open, b_close, b_fwd, b_bwd;
   logic signed [15:0] t_hi, t_cl;
   logic signed [16:0] diff17;
   logic signed [17:0] vel_x, mul_a, mul_b;
   logic [32:0]        thr_rnd;
   logic [18:0]        thr_sum;
   logic               p_neg;
   logic [35:0]        p_mag;
   logic [35:0]        p_rnd;
   logic [19:0]        r_mag;
   logic [19:0]        r_neg;
   logic [7:0]         claw_step;
   logic [8:0]         pos_up;
   logic [8:0]         pos_lim;

   assign ax_base  = read_axis(cfg.axis_select[3:0], a1_ff, a2_ff);
   assign ax_roll  = read_axis(cfg.axis_select[7:4], a1_ff, a2_ff);
   assign ax_act1  = read_axis(cfg.axis_select[11:8], a1_ff, a2_ff);
   assign ax_act2  = read_axis(cfg.axis_select[15:12], a1_ff, a2_ff);
   assign ax_elbow = read_axis(cfg.axis_select[19:16], a1_ff, a2_ff);
   assign ax_thr   = read_axis(cfg.axis_select[23:20], a1_ff, a2_ff);

   assign b_wplus  = bits_ff[cfg.button_select[3:0]];
   assign b_wminus = bits_ff[cfg.button_select[7:4]];
   assign b_open   = bits_ff[cfg.button_select[11:8]];
   assign b_close  = bits_ff[cfg.button_select[15:12]];
   assign b_fwd    = bits_ff[cfg.button_select[19:16]];
   assign b_bwd    = bits_ff[cfg.button_select[23:20]];

   // The throttle axis is limited to the high bound first, so a misordered pair
   // leaves the low bound in charge and the difference is never negative.
   assign t_hi   = (ax_thr > cfg.throttle_high) ? cfg.throttle_high : ax_thr;
   assign t_cl   = (t_hi < cfg.throttle_low) ? cfg.throttle_low : t_hi;
   assign diff17 = {t_cl[15], t_cl} - {cfg.throttle_low[15], cfg.throttle_low};

   always_comb begin
      case (cmd.issue_idx)
         VEL_BASE: begin
            vel_x = -ext18(ax_base);
         end
         VEL_SHOULDER: begin
            if (b_fwd) begin
               vel_x = COEF_SHOULDER_FWD;
            end else if (b_bwd) begin
               vel_x = COEF_SHOULDER_BWD;
            end else if ((ax_act1 > DZ_ACT1) || (ax_act1 < DZ_ACT1_NEG)) begin
               vel_x = -ext18(ax_act1);
            end else begin
               vel_x = 18'sd0;
            end
         end
         VEL_UPPER: begin
            if (b_fwd) begin
               vel_x = COEF_UPPER_FWD;
            end else if (b_bwd) begin
               vel_x = COEF_UPPER_BWD;
            end else begin
               vel_x = ext18(ax_act2);
            end
         end
         VEL_ELBOW: begin
            if ((ax_elbow <= DZ_ELBOW) && (ax_elbow >= DZ_ELBOW_NEG)) begin
               vel_x = 18'sd0;
            end else begin
               vel_x = ext18(ax_elbow);
            end
         end
         VEL_TILT: begin
            if (b_fwd) begin
               vel_x = COEF_ONE_NEG;
            end else if (b_bwd) begin
               vel_x = COEF_ONE;
            end else if (b_wplus && !b_wminus) begin
               vel_x = COEF_ONE;
            end else if (b_wminus && !b_wplus) begin
               vel_x = COEF_ONE_NEG;
            end else begin
               vel_x = 18'sd0;
            end
         end
         VEL_ROLL: begin
            vel_x = ext18(ax_roll);
         end
         default: begin
            vel_x = 18'sd0;
         end
      endcase
   end

   always_comb begin
      if (cmd.thr_issue) begin
         mul_a = {2'b00, diff17[15:0]};
         mul_b = {2'b00, cfg.throttle_gain};
      end else begin
         mul_a = vel_x;
         mul_b = {1'b0, thr_ff};
      end
   end

   assign prod_in = 36'(mul_a) * 36'(mul_b);

   assign thr_rnd = {1'b0, prod_ff[31:0]} + 33'd16384;
   assign thr_sum = {2'b00, THR_FLOOR} + {1'b0, thr_rnd[32:15]};

   always_comb begin
      if (cfg.axis_select[23]) begin
         thr_in = THR_ONE;
      end else if (thr_sum > {2'b00, THR_ONE}) begin
         thr_in = THR_ONE;
      end else begin
         thr_in = thr_sum[16:0];
      end
   end

   // Round half away from zero on the magnitude, then saturate.
   assign p_neg = prod_ff[35];
   assign p_mag = p_neg ? 36'(-prod_ff) : 36'(prod_ff);
   assign p_rnd = p_mag + 36'd32768;
   assign r_mag = p_rnd[35:16];
   assign r_neg = -r_mag;

   always_comb begin
      if (p_neg) begin
         vel_res = (r_mag > 20'd32768) ? -16'sd32768 : r_neg[15:0];
      end else begin
         vel_res = (r_mag > 20'd32767) ? 16'sd32767 : r_mag[15:0];
      end
   end

   assign claw_step = (cfg.claw_high >= cfg.claw_low) ?
                      8'((cfg.claw_high - cfg.claw_low) >> 1) : 8'd0;
   assign pos_up    = {1'b0, claw_pos_ff} + {1'b0, claw_step};
   assign pos_lim   = {1'b0, cfg.claw_low} + {1'b0, claw_step};

   always_comb begin
      claw_pos_in = claw_pos_ff;
      latch_in    = latch_ff;
      claw_req    = 1'b0;
      if (b_open && !latch_ff) begin
         latch_in = 1'b1;
         if (pos_up <= {1'b0, cfg.claw_high}) begin
            claw_pos_in = pos_up[7:0];
            claw_req    = 1'b1;
         end
      end else if (b_close && !latch_ff) begin
         latch_in = 1'b1;
         if ({1'b0, claw_pos_ff} >= pos_lim) begin
            claw_pos_in = claw_pos_ff - claw_step;
            claw_req    = 1'b1;
         end
      end else if (!b_open && !b_close) begin
         latch_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign status.out_free = !out_valid_ff || rsp_ready;
   assign rsp_valid       = out_valid_ff;
   assign rsp_payload     = out_pl_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         a1_ff   <= req_payload.axes_first;
         a2_ff   <= req_payload.axes_second;
         bits_ff <= req_payload.button_bits;
      end
      if (cmd.thr_issue || cmd.vel_issue) begin
         prod_ff <= prod_in;
      end
      if (cmd.thr_finish) begin
         thr_ff <= thr_in;
      end
      if (cmd.vel_finish) begin
         vel_ff[cmd.finish_idx] <= vel_res;
      end
      if (cmd.out_load) begin
         out_pl_ff.base_velocity     <= vel_ff[VEL_BASE];
         out_pl_ff.shoulder_velocity <= vel_ff[VEL_SHOULDER];
         out_pl_ff.upper_velocity    <= vel_ff[VEL_UPPER];
         out_pl_ff.elbow_velocity    <= vel_ff[VEL_ELBOW];
         out_pl_ff.tilt_velocity     <= vel_ff[VEL_TILT];
         out_pl_ff.roll_velocity     <= vel_ff[VEL_ROLL];
         out_pl_ff.claw_request      <= claw_req;
         out_pl_ff.claw_port         <= cfg.servo_channel;
         out_pl_ff.claw_position     <= claw_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         claw_pos_ff  <= CLAW_POSITION_RESET;
         latch_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (cmd.out_load) begin
            claw_pos_ff <= claw_pos_in;
            latch_ff    <= latch_in;
         end
      end
   end

endmodule

// File: rtl/joystick_arm_jog_mapper.sv
// Joystick arm jog mapper, top level; instantiates jajm_csr, jajm_ctrl and jajm_dp and uses
// jajm_pkg and jajm_stream_if. Each accepted joystick beat yields one result beat with six
// saturated joint velocities and the claw servo request. A sample is accepted only in idle, and
// the block then steps through the throttle product, its rounding, the six velocity products
// streamed through the single 18x18 multiplier with rounding overlapped, and the load of the
// output register before it returns to idle. The output register holds a finished result while
// the next sample is accepted and worked on; the block stalls only when a second result is
// ready before the first has been taken.
module joystick_arm_jog_mapper (
   input  logic                            clock,
   input  logic                            reset,
   jajm_stream_if.sink                     req_chan,
   jajm_stream_if.source                   rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [jajm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [jajm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [jajm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import jajm_pkg::*;

   cfg_type         cfg;
   cmd_type         cmd;
   status_type      status;
   req_payload_type req_pl;
   rsp_payload_type rsp_pl;

   assign req_pl           = req_chan.payload;
   assign rsp_chan.payload = rsp_pl;

   jajm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   jajm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   jajm_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_pl),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_payload (rsp_pl)
   );

`ifndef SYNTH
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("Result loaded over a beat that was not taken.");

   a_no_early_load: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (!cmd.out_load && !req_chan.ready))
      else $error("Result loaded or new beat taken right after an accepted beat.");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_chan.valid)
      else $error("Loaded result is not presented.");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.thr_issue, cmd.vel_issue, cmd.out_load}))
      else $error("Conflicting datapath commands in one cycle.");
`endif

endmodule
